/* src/bss_pkg.sv */
`timescale 1ns / 1ps

package bss_pkg;

  // session states, one-hot
  typedef enum logic [8:0] {
    ST_NEG   = 9'b000000001,
    ST_AUTH  = 9'b000000010,
    ST_READY = 9'b000000100,
    ST_STRM  = 9'b000001000,
    ST_TXRD  = 9'b000010000,
    ST_TXST  = 9'b000100000,
    ST_FAIL  = 9'b001000000,
    ST_INTR  = 9'b010000000,
    ST_DEAD  = 9'b100000000
  } state_t;

  // state codes as seen on the result channel
  localparam logic [3:0] SC_NEG   = 4'd0;
  localparam logic [3:0] SC_AUTH  = 4'd1;
  localparam logic [3:0] SC_READY = 4'd2;
  localparam logic [3:0] SC_STRM  = 4'd3;
  localparam logic [3:0] SC_TXRD  = 4'd4;
  localparam logic [3:0] SC_TXST  = 4'd5;
  localparam logic [3:0] SC_FAIL  = 4'd6;
  localparam logic [3:0] SC_INTR  = 4'd7;
  localparam logic [3:0] SC_DEAD  = 4'd8;

  // request kinds
  localparam logic [3:0] OP_HELLO    = 4'd0;
  localparam logic [3:0] OP_LOGON    = 4'd1;
  localparam logic [3:0] OP_LOGOFF   = 4'd2;
  localparam logic [3:0] OP_RUN      = 4'd3;
  localparam logic [3:0] OP_BEGIN    = 4'd4;
  localparam logic [3:0] OP_ROUTE    = 4'd5;
  localparam logic [3:0] OP_RESET    = 4'd6;
  localparam logic [3:0] OP_GOODBYE  = 4'd7;
  localparam logic [3:0] OP_PULL     = 4'd8;
  localparam logic [3:0] OP_DISCARD  = 4'd9;
  localparam logic [3:0] OP_COMMIT   = 4'd10;
  localparam logic [3:0] OP_ROLLBACK = 4'd11;

  // response kinds
  localparam logic [1:0] RK_SUCCESS = 2'd0;
  localparam logic [1:0] RK_FAILURE = 2'd1;
  localparam logic [1:0] RK_IGNORED = 2'd2;
  localparam logic [1:0] RK_RECORD  = 2'd3;

  // outcome of one transition
  typedef struct packed {
    state_t nxt;
    logic   bad;
  } trans_t;

  function automatic logic [3:0] state_code(state_t s);
    logic [3:0] c;
    c = SC_DEAD;
    unique case (s)
      ST_NEG:   c = SC_NEG;
      ST_AUTH:  c = SC_AUTH;
      ST_READY: c = SC_READY;
      ST_STRM:  c = SC_STRM;
      ST_TXRD:  c = SC_TXRD;
      ST_TXST:  c = SC_TXST;
      ST_FAIL:  c = SC_FAIL;
      ST_INTR:  c = SC_INTR;
      ST_DEAD:  c = SC_DEAD;
      default:  c = SC_DEAD;
    endcase
    return c;
  endfunction

endpackage

/* src/bss_in_if.sv */
`timescale 1ns / 1ps

interface bss_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [1:0] response_kind;
  logic       interrupt_event;

  modport source (output valid, output opcode, output response_kind,
                  output interrupt_event, input ready);
  modport sink   (input valid, input opcode, input response_kind,
                  input interrupt_event, output ready);
endinterface

/* src/bss_out_if.sv */
`timescale 1ns / 1ps

interface bss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] session_state;
  logic       illegal;

  modport source (output valid, output session_state, output illegal, input ready);
  modport sink   (input valid, input session_state, input illegal, output ready);
endinterface

/* src/bss_next.sv */
`timescale 1ns / 1ps

module bss_next (
  input  bss_pkg::state_t state,
  input  logic [3:0]      opcode,
  input  logic [1:0]      response_kind,
  input  logic            interrupt_event,
  output bss_pkg::trans_t res
);

  // success or failure picks a state, anything else is not allowed
  function automatic bss_pkg::trans_t pick_sf(logic [1:0] rk, bss_pkg::state_t s,
                                              bss_pkg::state_t f);
    bss_pkg::trans_t t;
    t.nxt = s;
    t.bad = 1'b0;
    if (rk == bss_pkg::RK_FAILURE) begin
      t.nxt = f;
    end else if (rk != bss_pkg::RK_SUCCESS) begin
      t.bad = 1'b1;
    end
    return t;
  endfunction

  // only an ignored response is allowed
  function automatic bss_pkg::trans_t pick_ig(logic [1:0] rk, bss_pkg::state_t d);
    bss_pkg::trans_t t;
    t.nxt = d;
    t.bad = (rk != bss_pkg::RK_IGNORED);
    return t;
  endfunction

  function automatic bss_pkg::trans_t go(bss_pkg::state_t d);
    bss_pkg::trans_t t;
    t.nxt = d;
    t.bad = 1'b0;
    return t;
  endfunction

  bss_pkg::trans_t tab;
  bss_pkg::trans_t nope;

  // per-state transition tables
  always_comb begin
    nope.nxt = state;
    nope.bad = 1'b1;
    tab      = nope;
    unique case (state)
      bss_pkg::ST_NEG: begin
        if (opcode == bss_pkg::OP_HELLO)
          tab = pick_sf(response_kind, bss_pkg::ST_AUTH, bss_pkg::ST_DEAD);
      end
      bss_pkg::ST_AUTH: begin
        if (opcode == bss_pkg::OP_LOGON)
          tab = pick_sf(response_kind, bss_pkg::ST_READY, bss_pkg::ST_DEAD);
      end
      bss_pkg::ST_READY: begin
        case (opcode)
          bss_pkg::OP_LOGOFF:
            tab = pick_sf(response_kind, bss_pkg::ST_AUTH, bss_pkg::ST_FAIL);
          bss_pkg::OP_RUN:
            tab = pick_sf(response_kind, bss_pkg::ST_STRM, bss_pkg::ST_FAIL);
          bss_pkg::OP_BEGIN:
            tab = pick_sf(response_kind, bss_pkg::ST_TXRD, bss_pkg::ST_FAIL);
          bss_pkg::OP_ROUTE:
            if (response_kind == bss_pkg::RK_SUCCESS) tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_RESET:   tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      bss_pkg::ST_STRM: begin
        case (opcode) inside
          bss_pkg::OP_PULL, bss_pkg::OP_DISCARD:
            tab = pick_sf(response_kind, bss_pkg::ST_READY, bss_pkg::ST_FAIL);
          bss_pkg::OP_RESET:   tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      bss_pkg::ST_TXRD: begin
        case (opcode) inside
          bss_pkg::OP_RUN:
            tab = pick_sf(response_kind, bss_pkg::ST_TXST, bss_pkg::ST_FAIL);
          bss_pkg::OP_COMMIT, bss_pkg::OP_ROLLBACK:
            tab = pick_sf(response_kind, bss_pkg::ST_READY, bss_pkg::ST_FAIL);
          bss_pkg::OP_RESET:   tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      bss_pkg::ST_TXST: begin
        case (opcode) inside
          bss_pkg::OP_RUN, bss_pkg::OP_PULL:
            tab = pick_sf(response_kind, bss_pkg::ST_TXST, bss_pkg::ST_FAIL);
          bss_pkg::OP_COMMIT:
            tab = pick_sf(response_kind, bss_pkg::ST_READY, bss_pkg::ST_FAIL);
          bss_pkg::OP_DISCARD:
            tab = pick_sf(response_kind, bss_pkg::ST_TXRD, bss_pkg::ST_FAIL);
          bss_pkg::OP_RESET:   tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      bss_pkg::ST_FAIL: begin
        case (opcode) inside
          bss_pkg::OP_RUN, bss_pkg::OP_PULL, bss_pkg::OP_DISCARD:
            tab = pick_ig(response_kind, bss_pkg::ST_FAIL);
          bss_pkg::OP_RESET:   tab = go(bss_pkg::ST_READY);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      bss_pkg::ST_INTR: begin
        case (opcode) inside
          bss_pkg::OP_RUN, bss_pkg::OP_PULL, bss_pkg::OP_DISCARD,
          bss_pkg::OP_BEGIN, bss_pkg::OP_COMMIT, bss_pkg::OP_ROLLBACK:
            tab = pick_ig(response_kind, bss_pkg::ST_FAIL);
          bss_pkg::OP_RESET:
            tab = pick_sf(response_kind, bss_pkg::ST_READY, bss_pkg::ST_DEAD);
          bss_pkg::OP_GOODBYE: tab = go(bss_pkg::ST_DEAD);
          default:             tab = nope;
        endcase
      end
      default: tab = nope;
    endcase
  end

  // interrupt first, then record responses, then the tables
  always_comb begin
    res.nxt = state;
    res.bad = 1'b0;
    if (interrupt_event) begin
      if (state == bss_pkg::ST_DEAD || !$onehot(state)) res.bad = 1'b1;
      else res.nxt = bss_pkg::ST_INTR;
    end else if (response_kind != bss_pkg::RK_RECORD) begin
      res.bad = tab.bad;
      if (!tab.bad) res.nxt = tab.nxt;
    end
  end

endmodule

/* src/bolt_session_state_machine.sv */
`timescale 1ns / 1ps

// path: a request beat waits in the request register, then its result waits in the result register
// throughput: one request beat per cycle while the result side keeps taking beats
// the session state is the only loop: it is looked up combinationally and updated on advance
// reset: synchronous, active low; state returns to negotiation and both the
// request register and the result register are emptied
module bolt_session_state_machine (
  input  logic       clk,
  input  logic       rst_n,
  bss_in_if.sink     in_ch,
  bss_out_if.source  out_ch
);

  logic            in_vld_r;
  logic [3:0]      op_r;
  logic [1:0]      rk_r;
  logic            irq_r;
  bss_pkg::state_t state_r;
  logic            out_vld_r;
  logic [3:0]      out_state_r;
  logic            out_ill_r;
  logic            advance;
  bss_pkg::trans_t res;

  // request register moves on when the result register is free or being drained
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      rk_r  <= in_ch.response_kind;
      irq_r <= in_ch.interrupt_event;
    end
  end

  // transition lookup
  bss_next u_next (
    .state           (state_r),
    .opcode          (op_r),
    .response_kind   (rk_r),
    .interrupt_event (irq_r),
    .res             (res)
  );

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::ST_NEG;
    end else if (advance) begin
      state_r <= res.nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= bss_pkg::state_code(res.nxt);
      out_ill_r   <= res.bad;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.session_state = out_state_r;
  assign out_ch.illegal       = out_ill_r;

`ifndef SYNTH
  // a refused event never moves the session
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.bad |=> state_r == $past(state_r))
    else $error("state moved on an illegal event");

  // the result beat carries the state just stored
  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r && out_state_r == bss_pkg::state_code(state_r))
    else $error("result beat disagrees with session state");

  // an empty result register never blocks the request side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("request side stalled with result register empty");

  // an interrupt outside defunct always lands in interrupted
  a_irq_enters: assert property (@(posedge clk) disable iff (!rst_n)
    advance && irq_r && state_r != bss_pkg::ST_DEAD |=>
      state_r == bss_pkg::ST_INTR && !out_ill_r)
    else $error("interrupt did not enter interrupted state");
`endif

endmodule
